[rtl/core/skvt_pkg.sv]
// Package for the sorted key-value table.
// Holds sizes, operation and status codes, and the request, response and cell types.
// No dependencies.
package skvt_pkg;

    localparam int CAPACITY    = 16;
    localparam int KEY_WIDTH   = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int KEY_IN_W = 32;
    localparam int VAL_IN_W = 32;
    localparam int ECOUNT_W = 5;

    typedef logic [FUNC_W-1:0]   func_t;
    typedef logic [STATUS_W-1:0] status_t;

    // operation codes
    localparam func_t FN_LOOKUP = 2'd0;
    localparam func_t FN_INSERT = 2'd1;
    localparam func_t FN_ERASE  = 2'd2;

    // status codes
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_PRESENT = 2'd1;
    localparam status_t ST_MISSING = 2'd2;
    localparam status_t ST_FULL    = 2'd3;

    typedef logic [KEY_WIDTH-1:0]   key_t;
    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [CNT_W-1:0]       count_t;

    typedef struct packed {
        func_t                func;
        logic [KEY_IN_W-1:0]  key_in;
        logic [VAL_IN_W-1:0]  value_in;
    } req_t;

    typedef struct packed {
        status_t              status;
        logic [VAL_IN_W-1:0]  value_out;
        logic [ECOUNT_W-1:0]  entry_count;
    } rsp_t;

    // broadcast to every cell
    typedef struct packed {
        logic   ins_en;
        logic   del_en;
        key_t   key;
        value_t value;
    } cell_cmd_t;

    // compare results of one cell
    typedef struct packed {
        logic lt;   // occupied and stored key below the search key
        logic eq;   // occupied and stored key equal to the search key
    } cell_flags_t;

endpackage

[rtl/core/skvt_cell.sv]
// One slot of the sorted key-value table: key/value storage plus compare.
// Shifts toward higher slots on insert, toward lower slots on erase.
// Depends on skvt_pkg.
module skvt_cell (
    input  logic                   clk,
    input  logic                   occupied,
    input  skvt_pkg::cell_cmd_t    cmd,
    input  logic                   left_lt,
    input  skvt_pkg::key_t         left_key,
    input  skvt_pkg::value_t       left_value,
    input  skvt_pkg::key_t         right_key,
    input  skvt_pkg::value_t       right_value,
    output skvt_pkg::key_t         key,
    output skvt_pkg::value_t       value,
    output skvt_pkg::cell_flags_t  flags
);
    import skvt_pkg::*;

    key_t   key_reg,   key_next;
    value_t value_reg, value_next;

    assign flags.lt = occupied && (key_reg < cmd.key);
    assign flags.eq = occupied && (key_reg == cmd.key);

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        if (cmd.ins_en && !flags.lt)
        begin
            // first slot not below the key takes the new pair, the rest move up
            if (left_lt)
            begin
                key_next   = cmd.key;
                value_next = cmd.value;
            end
            else
            begin
                key_next   = left_key;
                value_next = left_value;
            end
        end
        else if (cmd.del_en && !flags.lt)
        begin
            key_next   = right_key;
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign key   = key_reg;
    assign value = value_reg;

endmodule

[rtl/core/sorted_key_value_table.sv]
// Top level of the sorted key-value table: a row of skvt_cell slots, the
// occupancy counter and the response register.
// Depends on skvt_pkg and skvt_cell.
//
// The table holds up to CAPACITY unique key/value pairs in ascending unsigned
// key order, one pair per cell. When a request (lookup, insert or erase) is
// taken, every cell compares its key against the request key in
// parallel, the first cell whose key is not below it is the sorted position,
// and on insert or erase all cells at or above that position shift by one
// slot in the same edge. The response (status, value on a lookup hit, and the
// entry count after the operation) appears in the response register on the
// cycle after acceptance. Throughput is one request per cycle while no stall
// holds a waiting response. The parallel compare across the cell row and
// the OR reduction that picks the hit value are combinational. Request stall is
// raised only while a response waits in the register and the response side
// stalls. A duplicate key on insert reports key present before the capacity
// check; unused operation code 3 changes nothing and reports ok with zero value.
module sorted_key_value_table (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  skvt_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output skvt_pkg::rsp_t   rsp
);
    import skvt_pkg::*;

    count_t      count_reg, count_next;
    logic        rsp_valid_reg;
    rsp_t        rsp_reg, rsp_next;

    logic        accept;
    key_t        req_key;
    value_t      req_value;
    cell_cmd_t   cmd;

    key_t        cell_key   [CAPACITY];
    value_t      cell_value [CAPACITY];
    cell_flags_t cell_flags [CAPACITY];

    logic        hit;
    logic        full;
    value_t      hit_value;

    // one-deep response register; a new request is taken while it drains
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    assign req_key   = KEY_WIDTH'(req.key_in);
    assign req_value = VALUE_WIDTH'(req.value_in);
    assign full      = (count_reg == CNT_W'(CAPACITY));

    // keys are unique, so at most one cell matches
    always_comb
    begin
        hit       = 1'b0;
        hit_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit       = hit | cell_flags[i].eq;
            hit_value = hit_value | (cell_flags[i].eq ? cell_value[i] : '0);
        end
    end

    assign cmd.key    = req_key;
    assign cmd.value  = req_value;
    assign cmd.ins_en = accept && (req.func == FN_INSERT) && !hit && !full;
    assign cmd.del_en = accept && (req.func == FN_ERASE) && hit;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic   left_lt;
            key_t   left_key;
            value_t left_value;
            key_t   right_key;
            value_t right_value;

            if (g == 0)
            begin : g_head
                // virtual slot before the head is always below the key
                assign left_lt    = 1'b1;
                assign left_key   = '0;
                assign left_value = '0;
            end
            else
            begin : g_body
                assign left_lt    = cell_flags[g-1].lt;
                assign left_key   = cell_key[g-1];
                assign left_value = cell_value[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_tail
                // slot past the tail is never read after an erase
                assign right_key   = cell_key[g];
                assign right_value = cell_value[g];
            end
            else
            begin : g_inner
                assign right_key   = cell_key[g+1];
                assign right_value = cell_value[g+1];
            end

            skvt_cell u_cell (
                .clk         (clk),
                .occupied    (count_reg > CNT_W'(g)),
                .cmd         (cmd),
                .left_lt     (left_lt),
                .left_key    (left_key),
                .left_value  (left_value),
                .right_key   (right_key),
                .right_value (right_value),
                .key         (cell_key[g]),
                .value       (cell_value[g]),
                .flags       (cell_flags[g])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.del_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        rsp_next.status    = ST_OK;
        rsp_next.value_out = '0;
        case (req.func)
            FN_LOOKUP:
            begin
                if (hit)
                begin
                    rsp_next.value_out = VAL_IN_W'(hit_value);
                end
                else
                begin
                    rsp_next.status = ST_MISSING;
                end
            end
            FN_INSERT:
            begin
                if (hit)
                begin
                    rsp_next.status = ST_PRESENT;
                end
                else if (full)
                begin
                    rsp_next.status = ST_FULL;
                end
            end
            FN_ERASE:
            begin
                if (!hit)
                begin
                    rsp_next.status = ST_MISSING;
                end
            end
            default:
            begin
                rsp_next.status = ST_OK;
            end
        endcase
        rsp_next.entry_count = ECOUNT_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // occupancy never passes the number of cells
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    // a successful insert grows the table by exactly one
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_en |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow occupancy");

    // a successful erase shrinks the table by exactly one
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.del_en |=> count_reg == $past(count_reg) - 1'b1)
        else $error("erase did not shrink occupancy");

    // every accepted request leaves a response in the register
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("accepted request produced no response");

    // table full is only reported when every cell is in use
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.status == ST_FULL) |-> full)
        else $error("table full reported with free cells");

endmodule
